// ===== rtl/rsi_pkg.sv =====
// Shared constants, types and helpers for the radix string-to-integer parser.
`timescale 1ns / 1ps
`default_nettype none

package rsi_pkg;

    localparam int ALPHA_SLOTS    = 16;
    localparam int CH_W           = 8;
    localparam int VAL_W          = 64;
    localparam int CNT_W          = 5;
    localparam int IDX_W          = 4;
    localparam int CFG_IDX_W      = 2;
    localparam int MAX_DIGITS_DEF = 16;

    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CH_W-1:0] CH_CR    = 8'd13;
    localparam logic [CH_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LOW   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HIGH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_COUNT = 2'd2;

    typedef struct packed {
        logic [ALPHA_SLOTS-1:0][CH_W-1:0] alpha;
        logic [CNT_W-1:0]                 count;
    } t_cfg;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
    } t_digit;

    function automatic logic is_blank(input logic [CH_W-1:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

// ===== rtl/rsi_cfg_regs.sv =====
// Configuration registers: alphabet bytes and digit count.
`timescale 1ns / 1ps
`default_nettype none

module rsi_cfg_regs
    import rsi_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [VAL_W-1:0]     i_cfg_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ALPHA_LOW:   r_cfg.alpha[7:0]  <= i_cfg_data;
                CFG_ALPHA_HIGH:  r_cfg.alpha[15:8] <= i_cfg_data;
                CFG_DIGIT_COUNT: r_cfg.count       <= i_cfg_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rsi_alphabet.sv =====
// Alphabet logic: parallel digit match, radix in use and alphabet validity.
`timescale 1ns / 1ps
`default_nettype none

module rsi_alphabet
    import rsi_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  wire t_cfg             i_cfg,
    input  wire logic [CH_W-1:0]  i_ch,
    output t_digit                o_digit,
    output logic [CNT_W-1:0]      o_radix,
    output logic                  o_base_ok
);

    localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_DIGITS);

    always_comb begin
        o_radix = (i_cfg.count > MaxCnt) ? MaxCnt : i_cfg.count;
    end

    // lowest matching slot wins
    always_comb begin
        o_digit = '0;
        for (int i = ALPHA_SLOTS - 1; i >= 0; i--) begin
            if ((CNT_W'(i) < o_radix) && (i_cfg.alpha[i] == i_ch)) begin
                o_digit.hit = 1'b1;
                o_digit.idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        o_base_ok = (i_cfg.count >= CNT_W'(2)) && (i_cfg.count <= MaxCnt);
        for (int i = 0; i < ALPHA_SLOTS; i++) begin
            if (CNT_W'(i) < i_cfg.count) begin
                if ((i_cfg.alpha[i] == CH_NUL) || (i_cfg.alpha[i] == CH_PLUS) ||
                    (i_cfg.alpha[i] == CH_MINUS) || is_blank(i_cfg.alpha[i])) begin
                    o_base_ok = 1'b0;
                end
                for (int j = i + 1; j < ALPHA_SLOTS; j++) begin
                    if ((CNT_W'(j) < i_cfg.count) && (i_cfg.alpha[j] == i_cfg.alpha[i])) begin
                        o_base_ok = 1'b0;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/radix_string_to_integer.sv =====
// Top level: character stream parser producing a signed 64-bit integer.
// Usage:
//   Characters arrive one item per cycle on the input channel (i_in_valid /
//   o_in_ready, payload i_ch and i_last). Leading blanks are skipped, a run of
//   signs sets the polarity, digits of the configured alphabet accumulate.
//   The item flagged last yields one result on the output channel
//   (o_out_valid / i_out_ready, payload o_value, o_base_ok, o_overflowed)
//   and the next item starts a new string.
//   Path: an accepted item lands in the input register, is parsed from there
//   and the result of a last item is written to the output register, which
//   drives o_out_valid.
//   Throughput: one item per cycle while no last item waits for the output
//   register, set by the 64 x 5 multiply-add that feeds the parse state back.
//   Stall: while a result waits, non-last items keep flowing; a last item
//   waits in the input register until the output register frees.
//   Reset clears parse state, both valid flags and the configuration.
//   Configuration writes (i_cfg_valid, i_cfg_index, i_cfg_data) are always
//   accepted and should only be made while no string is in progress.
`timescale 1ns / 1ps
`default_nettype none

module radix_string_to_integer
    import rsi_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [VAL_W-1:0]     i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [CH_W-1:0]      i_ch,
    input  wire logic                 i_last,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic signed [VAL_W-1:0]   o_value,
    output logic                      o_base_ok,
    output logic                      o_overflowed
);

    typedef enum logic [1:0] {
        PH_SPACE = 2'd0,
        PH_SIGN  = 2'd1,
        PH_DIGIT = 2'd2,
        PH_STOP  = 2'd3
    } t_phase;

    t_cfg               cfg;
    t_digit             digit;
    logic [CNT_W-1:0]   radix;
    logic               base_ok;

    logic               r_in_valid;
    logic [CH_W-1:0]    r_ch;
    logic               r_last;

    t_phase             r_phase, n_phase;
    logic               r_negative, n_negative;
    logic [VAL_W-1:0]   r_acc, n_acc;
    logic               r_wrap, n_wrap;

    logic               r_out_valid;
    logic [VAL_W-1:0]   r_value, n_value;
    logic               r_base_ok;
    logic               r_overflowed, n_overflowed;

    logic [VAL_W+CNT_W-1:0] prod;
    logic                   in_accept;
    logic                   out_free;
    logic                   s1_go;

    rsi_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    rsi_alphabet #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_alpha (
        .i_cfg     (cfg),
        .i_ch      (r_ch),
        .o_digit   (digit),
        .o_radix   (radix),
        .o_base_ok (base_ok)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_go      = r_in_valid && (!r_last || out_free);
    assign o_in_ready = !r_in_valid || s1_go;
    assign in_accept  = i_in_valid && o_in_ready;

    // bits above 63 set means acc * radix + d no longer fits
    assign prod = ({{CNT_W{1'b0}}, r_acc} * {{VAL_W{1'b0}}, radix})
                + {{(VAL_W+CNT_W-IDX_W){1'b0}}, digit.idx};

    always_comb begin
        n_phase    = r_phase;
        n_negative = r_negative;
        n_acc      = r_acc;
        n_wrap     = r_wrap;
        priority if ((r_phase == PH_SPACE) && is_blank(r_ch)) begin
        end else if (((r_phase == PH_SPACE) || (r_phase == PH_SIGN)) &&
                     ((r_ch == CH_PLUS) || (r_ch == CH_MINUS))) begin
            n_phase = PH_SIGN;
            if (r_ch == CH_MINUS) begin
                n_negative = ~r_negative;
            end
        end else if (r_phase != PH_STOP) begin
            if (digit.hit) begin
                n_phase = PH_DIGIT;
                n_acc   = prod[VAL_W-1:0];
                if (prod[VAL_W+CNT_W-1:VAL_W] != '0) begin
                    n_wrap = 1'b1;
                end
            end else begin
                n_phase = PH_STOP;
            end
        end
    end

    always_comb begin
        if (base_ok) begin
            n_value      = n_negative ? (~n_acc + VAL_W'(1)) : n_acc;
            n_overflowed = n_wrap;
        end else begin
            n_value      = '0;
            n_overflowed = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_SPACE;
            r_negative  <= 1'b0;
            r_acc       <= '0;
            r_wrap      <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
                r_ch       <= i_ch;
                r_last     <= i_last;
            end else if (s1_go) begin
                r_in_valid <= 1'b0;
            end

            if (s1_go) begin
                if (r_last) begin
                    r_phase    <= PH_SPACE;
                    r_negative <= 1'b0;
                    r_acc      <= '0;
                    r_wrap     <= 1'b0;
                end else begin
                    r_phase    <= n_phase;
                    r_negative <= n_negative;
                    r_acc      <= n_acc;
                    r_wrap     <= n_wrap;
                end
            end

            if (s1_go && r_last) begin
                r_out_valid  <= 1'b1;
                r_value      <= n_value;
                r_base_ok    <= base_ok;
                r_overflowed <= n_overflowed;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_value      = r_value;
    assign o_base_ok    = r_base_ok;
    assign o_overflowed = r_overflowed;

    a_bad_base_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_base_ok) |-> ((o_value == '0) && !o_overflowed))
        else $error("invalid alphabet result not zero");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && r_last) |=> ((r_phase == PH_SPACE) && !r_negative &&
                               (r_acc == '0) && !r_wrap))
        else $error("parse state not cleared after last item");

    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && r_last) |=> r_out_valid)
        else $error("last item gave no result");

    a_stop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == PH_STOP) && !(s1_go && r_last)) |=> (r_phase == PH_STOP))
        else $error("parser left stopped phase before string end");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_last && r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("last item overtaken while result pending");

endmodule

`default_nettype wire

// ===== test/radix_string_to_integer_tb.sv =====
// Self-checking testbench for radix_string_to_integer: drives strings and alphabets, predicts parses.
`timescale 1ns / 1ps

module radix_string_to_integer_tb;
    import rsi_pkg::*;

    localparam int RADIX_MAX     = MAX_DIGITS_DEF;
    localparam int SETTLE_CYCLES = 4;
    localparam int LONG_HOLD     = 300;
    localparam int LIMIT         = 1000000;

    localparam logic [VAL_W-1:0] VAL_ALL_ONES = '1;

    typedef enum logic [1:0] {
        PH_BLANKS,
        PH_SIGNS,
        PH_DIGITS,
        PH_STOPPED
    } t_scan_phase;

    typedef struct {
        logic [VAL_W-1:0] value;
        logic             base_ok;
        logic             overflowed;
    } t_parsed;

    // Shadow of the parser: alphabet registers, scan state and the parses still owed.
    class parse_checker;
        logic [VAL_W-1:0] alpha_lo;
        logic [VAL_W-1:0] alpha_hi;
        logic [CNT_W-1:0] count;
        t_scan_phase      ph;
        logic             neg;
        logic             wrapped;
        logic [VAL_W-1:0] acc;
        t_parsed          owed_q[$];
        int               faults;

        function new();
            alpha_lo = '0;
            alpha_hi = '0;
            count    = '0;
            faults   = 0;
            clear();
        endfunction

        function void clear();
            ph      = PH_BLANKS;
            neg     = 1'b0;
            acc     = '0;
            wrapped = 1'b0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] data);
            case (idx)
                CFG_ALPHA_LOW:   alpha_lo = data;
                CFG_ALPHA_HIGH:  alpha_hi = data;
                CFG_DIGIT_COUNT: count = data[CNT_W-1:0];
                default: begin
                end
            endcase
        endfunction

        function logic [CH_W-1:0] digit_char(int k);
            return (k < 8) ? alpha_lo[8*k +: 8] : alpha_hi[8*(k-8) +: 8];
        endfunction

        function int radix();
            return (count > RADIX_MAX) ? RADIX_MAX : int'(count);
        endfunction

        function bit blank(logic [CH_W-1:0] c);
            return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
        endfunction

        function bit alphabet_ok();
            int n;
            logic [CH_W-1:0] c;
            n = int'(count);
            if (n < 2 || n > RADIX_MAX)
                return 1'b0;
            for (int i = 0; i < n; i++) begin
                c = digit_char(i);
                if (c == CH_NUL || c == CH_PLUS || c == CH_MINUS || blank(c))
                    return 1'b0;
                for (int j = i + 1; j < n; j++)
                    if (digit_char(j) == c)
                        return 1'b0;
            end
            return 1'b1;
        endfunction

        function int digit_value(logic [CH_W-1:0] c);
            for (int i = 0; i < radix(); i++)
                if (digit_char(i) == c)
                    return i;
            return -1;
        endfunction

        function void note_char(logic [CH_W-1:0] c, logic lst);
            int d;
            logic [VAL_W-1:0] r;
            logic [VAL_W-1:0] dv;
            t_parsed res;
            if (ph == PH_BLANKS && blank(c)) begin
            end else if ((ph == PH_BLANKS || ph == PH_SIGNS) &&
                         (c == CH_PLUS || c == CH_MINUS)) begin
                ph = PH_SIGNS;
                if (c == CH_MINUS)
                    neg = ~neg;
            end else if (ph != PH_STOPPED) begin
                d = digit_value(c);
                if (d >= 0) begin
                    ph = PH_DIGITS;
                    r  = VAL_W'(radix());
                    dv = {{(VAL_W-4){1'b0}}, d[3:0]};
                    if (r != 0 && acc > (VAL_ALL_ONES - dv) / r)
                        wrapped = 1'b1;
                    acc = acc * r + dv;
                end else begin
                    ph = PH_STOPPED;
                end
            end
            if (!lst)
                return;
            if (alphabet_ok()) begin
                res.value      = neg ? ({VAL_W{1'b0}} - acc) : acc;
                res.base_ok    = 1'b1;
                res.overflowed = wrapped;
            end else begin
                res.value      = '0;
                res.base_ok    = 1'b0;
                res.overflowed = 1'b0;
            end
            owed_q.push_back(res);
            clear();
        endfunction

        function void check_result(logic [VAL_W-1:0] v, logic ok, logic ovf);
            t_parsed exp;
            if (owed_q.size() == 0) begin
                if (faults < 10)
                    $display("unexpected result: value %h base_ok %b overflowed %b", v, ok, ovf);
                faults++;
                return;
            end
            exp = owed_q.pop_front();
            if (v !== exp.value || ok !== exp.base_ok || ovf !== exp.overflowed) begin
                if (faults < 10)
                    $display("mismatch at %0t: value %h/%h base_ok %b/%b overflowed %b/%b (exp/got)",
                             $realtime, exp.value, v, exp.base_ok, ok, exp.overflowed, ovf);
                faults++;
            end
        endfunction

        function int waiting();
            return owed_q.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [VAL_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [CH_W-1:0]      i_ch;
    logic                 i_last;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic signed [VAL_W-1:0] o_value;
    logic                 o_base_ok;
    logic                 o_overflowed;

    parse_checker sb;
    int           items_sent = 0;
    int           cycles = 0;
    bit           tx_calm = 1'b0;
    bit           rx_calm = 1'b0;
    bit           hold_req = 1'b0;

    radix_string_to_integer #(
        .MAX_DIGITS(RADIX_MAX)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_ch         (i_ch),
        .i_last       (i_last),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_value      (o_value),
        .o_base_ok    (o_base_ok),
        .o_overflowed (o_overflowed)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_value, o_base_ok, o_overflowed);
    end

    function automatic int pick_gap(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CH_W-1:0] blank_pick();
        int r;
        r = $urandom_range(0, 6);
        return (r >= 5) ? CH_SPACE : CH_TAB + CH_W'(r);
    endfunction

    // unused slots get random bytes so every bit of the data words moves
    function automatic logic [127:0] alpha_from_text(input string s);
        logic [127:0] a;
        a = {$urandom, $urandom, $urandom, $urandom};
        for (int k = 0; k < s.len(); k++)
            a[8*k +: 8] = s[k];
        return a;
    endfunction

    function automatic logic [127:0] distinct_alphabet();
        logic [127:0] a;
        logic [255:0] taken;
        logic [CH_W-1:0] c;
        taken = '0;
        for (int k = 0; k < 16; k++) begin
            do
                c = CH_W'($urandom_range(1, 255));
            while (taken[c] || c == CH_PLUS || c == CH_MINUS || c == CH_SPACE ||
                   (c >= CH_TAB && c <= CH_CR));
            taken[c]     = 1'b1;
            a[8*k +: 8]  = c;
        end
        return a;
    endfunction

    // entered and left at a falling edge
    task automatic push_char(input logic [CH_W-1:0] c, input logic lst);
        int gap;
        gap = pick_gap(tx_calm);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_ch       <= c;
        i_last     <= lst;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        sb.note_char(c, lst);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic push_text(input string s, input bit close);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i], close && (i == s.len() - 1));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        sb.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    // only once every owed parse is out and the pipe has settled
    task automatic load_alphabet(input logic [127:0] a, input logic [CNT_W-1:0] n);
        i_in_valid <= 1'b0;
        while (sb.waiting() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        write_reg(CFG_ALPHA_LOW, a[63:0]);
        write_reg(CFG_ALPHA_HIGH, a[127:64]);
        write_reg(CFG_DIGIT_COUNT, {{(VAL_W-CNT_W){1'b0}}, n});
        i_cfg_valid <= 1'b0;
    endtask

    // blanks, signs, digits of the live alphabet, then an optional tail; one character may be replaced at random
    task automatic send_number();
        logic [CH_W-1:0] q[$];
        int n;
        int rdx;
        rdx = sb.radix();
        n = $urandom_range(0, 3);
        repeat (n) q.push_back(blank_pick());
        n = $urandom_range(0, 1) ? $urandom_range(1, 3) : 0;
        repeat (n) q.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        if (rdx > 0)
            repeat (n) q.push_back(sb.digit_char($urandom_range(0, rdx - 1)));
        case ($urandom_range(0, 3))
            0: q.push_back(CH_NUL);
            1: repeat ($urandom_range(1, 3)) q.push_back(CH_W'($urandom));
            default: begin
            end
        endcase
        if (q.size() > 0 && $urandom_range(0, 9) == 0)
            q[$urandom_range(0, q.size() - 1)] = CH_W'($urandom);
        if (q.size() == 0)
            q.push_back(CH_W'($urandom));
        foreach (q[i])
            push_char(q[i], i == q.size() - 1);
    endtask

    task automatic run_strings(input int budget);
        int start;
        bit open;
        bit lst;
        start = items_sent;
        open  = 1'b0;
        while (items_sent - start < budget) begin
            if ($urandom_range(0, 19) == 0) begin
                tx_calm = ($urandom_range(0, 2) == 0);
                rx_calm = ($urandom_range(0, 2) == 0);
            end
            if ($urandom_range(0, 9) < 8) begin
                send_number();
                open = 1'b0;
            end else begin
                lst = ($urandom_range(0, 3) == 0);
                push_char(CH_W'($urandom), lst);
                open = !lst;
            end
        end
        if (open)
            push_char(CH_W'($urandom), 1'b1);
    endtask

    initial begin : out_side
        int stall;
        i_out_ready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
            end else begin
                stall = pick_gap(rx_calm);
                if (stall > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (stall) @(negedge i_clk);
                end
                i_out_ready <= 1'b1;
                @(negedge i_clk);
            end
        end
    end

    initial begin : stimulus
        logic [127:0] a;
        sb          = new();
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_ch        = '0;
        i_last      = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // registers still at reset: empty alphabet, nothing parses
        run_strings(40);

        load_alphabet(alpha_from_text("0123456789"), 5'd10);
        push_text(" \011\012\013\014\015-+-9", 1'b1);
        push_text("-7x5", 1'b1);
        push_text("3", 1'b0);
        push_char(CH_NUL, 1'b1);
        push_char(8'hFF, 1'b1);
        push_text("+", 1'b1);
        push_text("8", 1'b0);
        push_text("1", 1'b1);
        run_strings(200);

        load_alphabet(alpha_from_text("0123456789abcdef"), 5'd16);
        hold_req = 1'b1;
        run_strings(250);

        load_alphabet(alpha_from_text("01"), 5'd2);
        run_strings(150);

        // count beyond the limit: digits still match but the base is rejected
        load_alphabet(alpha_from_text("0123456789ABCDEF"), 5'd31);
        run_strings(100);

        load_alphabet(alpha_from_text("0123456789"), 5'd1);
        run_strings(60);

        load_alphabet(alpha_from_text("0123456729"), 5'd10);
        run_strings(60);

        // a sign inside the alphabet counts as a digit once digits have begun
        load_alphabet(alpha_from_text("01+3456789"), 5'd10);
        run_strings(50);
        load_alphabet(alpha_from_text("0123-56789"), 5'd10);
        run_strings(50);

        a = alpha_from_text("0123456789");
        a[8*4 +: 8] = CH_NUL;
        load_alphabet(a, 5'd10);
        run_strings(50);
        a[8*4 +: 8] = CH_CR;
        load_alphabet(a, 5'd10);
        run_strings(50);

        for (int k = 0; k < 4; k++) begin
            load_alphabet(distinct_alphabet(), CNT_W'($urandom_range(2, 16)));
            if (k == 1)
                hold_req = 1'b1;
            run_strings(175);
        end

        for (int k = 0; k < 2; k++) begin
            load_alphabet({$urandom, $urandom, $urandom, $urandom},
                          CNT_W'($urandom_range(0, 31)));
            run_strings(80);
        end

        i_in_valid <= 1'b0;
        while (sb.waiting() != 0)
            @(posedge i_clk);
        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);
        if (sb.faults == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
